// ===== rtl/rau_pkg.sv =====
`default_nettype none

package rau_pkg;

  // Operation codes
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_SUB = 2'd1;
  localparam logic [1:0] CMD_MUL = 2'd2;
  localparam logic [1:0] CMD_DIV = 2'd3;

  // Per-beat flags that ride along the pipeline
  typedef struct packed {
    logic dz;
    logic neg;
    logic eq;
    logic lt;
    logic gt;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/rau_gcd.sv =====
`default_nettype none

module rau_gcd import rau_pkg::*; #(
  parameter int MW = 31
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  input  wire logic [MW-1:0]                in_num,
  input  wire logic [MW-1:0]                in_den,
  input  wire side_t                        in_side,
  output logic                              out_valid,
  output logic [MW-1:0]                     out_odd,
  output logic [$clog2(MW+1)-1:0]           out_shift,
  output logic [MW-1:0]                     out_num,
  output logic [MW-1:0]                     out_den,
  output side_t                             out_side
);

  localparam int NS = 2 * MW;
  localparam int KW = $clog2(MW + 1);

  logic          v      [NS];
  logic [MW-1:0] x      [NS];
  logic [MW-1:0] y      [NS];
  logic [KW-1:0] k      [NS];
  logic [MW-1:0] un     [NS];
  logic [MW-1:0] ud     [NS];
  side_t         sd     [NS];

  logic          v_next [NS];
  logic [MW-1:0] x_next [NS];
  logic [MW-1:0] y_next [NS];
  logic [KW-1:0] k_next [NS];
  logic [MW-1:0] un_next[NS];
  logic [MW-1:0] ud_next[NS];
  side_t         sd_next[NS];

  // One binary gcd step per stage
  always_comb begin
    logic [MW-1:0] px, py;
    logic [KW-1:0] pk;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        v_next[s]  = in_valid;
        px         = in_num;
        py         = in_den;
        pk         = '0;
        un_next[s] = in_num;
        ud_next[s] = in_den;
        sd_next[s] = in_side;
      end else begin
        v_next[s]  = v[s-1];
        px         = x[s-1];
        py         = y[s-1];
        pk         = k[s-1];
        un_next[s] = un[s-1];
        ud_next[s] = ud[s-1];
        sd_next[s] = sd[s-1];
      end
      x_next[s] = px;
      y_next[s] = py;
      k_next[s] = pk;
      priority if (px == '0 || py == '0) begin
        x_next[s] = px;
      end else if (!px[0] && !py[0]) begin
        x_next[s] = px >> 1;
        y_next[s] = py >> 1;
        k_next[s] = pk + KW'(1);
      end else if (!px[0]) begin
        x_next[s] = px >> 1;
      end else if (!py[0]) begin
        y_next[s] = py >> 1;
      end else if (px >= py) begin
        x_next[s] = (px - py) >> 1;
      end else begin
        y_next[s] = (py - px) >> 1;
      end
    end
  end

  // Advance all stages
  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else begin
        v[s] <= v_next[s];
      end
      x[s]  <= x_next[s];
      y[s]  <= y_next[s];
      k[s]  <= k_next[s];
      un[s] <= un_next[s];
      ud[s] <= ud_next[s];
      sd[s] <= sd_next[s];
    end
  end

  assign out_valid = v[NS-1];
  assign out_odd   = x[NS-1] | y[NS-1];
  assign out_shift = k[NS-1];
  assign out_num   = un[NS-1];
  assign out_den   = ud[NS-1];
  assign out_side  = sd[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rau_div.sv =====
`default_nettype none

module rau_div import rau_pkg::*; #(
  parameter int MW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [MW-1:0] in_num,
  input  wire logic [MW-1:0] in_den,
  input  wire logic [MW-1:0] in_gcd,
  input  wire side_t         in_side,
  output logic               out_valid,
  output logic [MW-1:0]      out_qn,
  output logic [MW-1:0]      out_qd,
  output side_t              out_side
);

  localparam int NS = MW;

  logic          v      [NS];
  logic [MW-1:0] rn     [NS];
  logic [MW-1:0] rd     [NS];
  logic [MW-1:0] dn     [NS];
  logic [MW-1:0] dd     [NS];
  logic [MW-1:0] qn     [NS];
  logic [MW-1:0] qd     [NS];
  logic [MW-1:0] gg     [NS];
  side_t         sd     [NS];

  logic          v_next [NS];
  logic [MW-1:0] rn_next[NS];
  logic [MW-1:0] rd_next[NS];
  logic [MW-1:0] dn_next[NS];
  logic [MW-1:0] dd_next[NS];
  logic [MW-1:0] qn_next[NS];
  logic [MW-1:0] qd_next[NS];
  logic [MW-1:0] gg_next[NS];
  side_t         sd_next[NS];

  // One restoring quotient bit per stage, numerator and denominator side by side
  always_comb begin
    logic [MW-1:0] prn, prd, pdn, pdd, pqn, pqd, pg;
    logic [MW:0]   part_n, part_d;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        v_next[s] = in_valid;
        prn = '0;
        prd = '0;
        pdn = in_num;
        pdd = in_den;
        pqn = '0;
        pqd = '0;
        pg  = in_gcd;
        sd_next[s] = in_side;
      end else begin
        v_next[s] = v[s-1];
        prn = rn[s-1];
        prd = rd[s-1];
        pdn = dn[s-1];
        pdd = dd[s-1];
        pqn = qn[s-1];
        pqd = qd[s-1];
        pg  = gg[s-1];
        sd_next[s] = sd[s-1];
      end
      part_n = {prn, pdn[MW-1]};
      part_d = {prd, pdd[MW-1]};
      dn_next[s] = pdn << 1;
      dd_next[s] = pdd << 1;
      gg_next[s] = pg;
      if (part_n >= {1'b0, pg}) begin
        rn_next[s] = MW'(part_n - {1'b0, pg});
        qn_next[s] = {pqn[MW-2:0], 1'b1};
      end else begin
        rn_next[s] = part_n[MW-1:0];
        qn_next[s] = {pqn[MW-2:0], 1'b0};
      end
      if (part_d >= {1'b0, pg}) begin
        rd_next[s] = MW'(part_d - {1'b0, pg});
        qd_next[s] = {pqd[MW-2:0], 1'b1};
      end else begin
        rd_next[s] = part_d[MW-1:0];
        qd_next[s] = {pqd[MW-2:0], 1'b0};
      end
    end
  end

  // Advance all stages
  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (rst) begin
        v[s] <= 1'b0;
      end else begin
        v[s] <= v_next[s];
      end
      rn[s] <= rn_next[s];
      rd[s] <= rd_next[s];
      dn[s] <= dn_next[s];
      dd[s] <= dd_next[s];
      qn[s] <= qn_next[s];
      qd[s] <= qd_next[s];
      gg[s] <= gg_next[s];
      sd[s] <= sd_next[s];
    end
  end

  assign out_valid = v[NS-1];
  assign out_qn    = qn[NS-1];
  assign out_qd    = qd[NS-1];
  assign out_side  = sd[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
`default_nettype none

// Path from start to result_valid: cross products, magnitudes and compare, gcd stages, divider stages, output register.
// Throughput: one beat per cycle; busy is never raised.
// Depth comes from one binary gcd step per stage plus one quotient bit per divider stage.
// Reset (rst, synchronous) clears all valid bits; the receiver cannot stall results.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               command,
  input  wire logic [OPERAND_WIDTH-1:0] a_num,
  input  wire logic [OPERAND_WIDTH-2:0] a_den,
  input  wire logic [OPERAND_WIDTH-1:0] b_num,
  input  wire logic [OPERAND_WIDTH-2:0] b_den,
  output logic                          result_valid,
  output logic [31:0]                   result_num,
  output logic [30:0]                   result_den,
  output logic                          div_zero,
  output logic                          cmp_equal,
  output logic                          cmp_less,
  output logic                          cmp_greater
);

  localparam int W   = OPERAND_WIDTH;
  localparam int PW  = 2 * W;
  localparam int MW  = 2 * W - 1;
  localparam int KW  = $clog2(MW + 1);
  localparam int XW  = (MW > 32) ? MW : 32;
  localparam int LAT = 3 * MW + 3;

  assign busy = 1'b0;

  // Stage A: cross products
  logic                 a_v;
  logic [1:0]           a_cmd;
  logic signed [PW-1:0] lhs, rhs, prod_nn, den_bn;
  logic [PW-3:0]        den_bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else begin
      a_v <= start && !busy;
    end
    a_cmd   <= command;
    lhs     <= $signed(a_num) * $signed({1'b0, b_den});
    rhs     <= $signed(b_num) * $signed({1'b0, a_den});
    prod_nn <= $signed(a_num) * $signed(b_num);
    den_bn  <= $signed({1'b0, a_den}) * $signed(b_num);
    den_bd  <= a_den * b_den;
  end

  // Stage B: select raw fraction, take magnitudes and compare
  logic signed [PW-1:0] raw_num, raw_den, neg_num, neg_den;
  logic                 b_v;
  logic [MW-1:0]        b_un, b_ud;
  side_t                b_side;

  always_comb begin
    unique case (a_cmd)
      CMD_ADD: raw_num = lhs + rhs;
      CMD_SUB: raw_num = lhs - rhs;
      CMD_MUL: raw_num = prod_nn;
      CMD_DIV: raw_num = lhs;
      default: raw_num = lhs;
    endcase
    raw_den = (a_cmd == CMD_DIV) ? den_bn : $signed({2'b00, den_bd});
    neg_num = -raw_num;
    neg_den = -raw_den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else begin
      b_v <= a_v;
    end
    b_un       <= raw_num[PW-1] ? neg_num[MW-1:0] : raw_num[MW-1:0];
    b_ud       <= raw_den[PW-1] ? neg_den[MW-1:0] : raw_den[MW-1:0];
    b_side.dz  <= (raw_den == '0);
    b_side.neg <= raw_num[PW-1] ^ raw_den[PW-1];
    b_side.eq  <= (lhs == rhs);
    b_side.lt  <= (lhs < rhs);
    b_side.gt  <= (lhs > rhs);
  end

  // Gcd pipeline
  logic          g_v;
  logic [MW-1:0] g_odd, g_un, g_ud, g_val;
  logic [KW-1:0] g_k;
  side_t         g_side;

  rau_gcd #(.MW(MW)) u_gcd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (b_v),
    .in_num    (b_un),
    .in_den    (b_ud),
    .in_side   (b_side),
    .out_valid (g_v),
    .out_odd   (g_odd),
    .out_shift (g_k),
    .out_num   (g_un),
    .out_den   (g_ud),
    .out_side  (g_side)
  );

  // Restore common power of two
  assign g_val = g_odd << g_k;

  // Divide both parts by the gcd
  logic          d_v;
  logic [MW-1:0] d_qn, d_qd;
  side_t         d_side;

  rau_div #(.MW(MW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (g_v),
    .in_num    (g_un),
    .in_den    (g_ud),
    .in_gcd    (g_val),
    .in_side   (g_side),
    .out_valid (d_v),
    .out_qn    (d_qn),
    .out_qd    (d_qd),
    .out_side  (d_side)
  );

  // Output beat: apply sign, zero on division by zero
  logic [XW-1:0] qn_ext, qd_ext;
  logic [31:0]   qn32;

  assign qn_ext = XW'(d_qn);
  assign qd_ext = XW'(d_qd);
  assign qn32   = qn_ext[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= d_v;
    end
    if (d_side.dz) begin
      result_num <= '0;
      result_den <= '0;
    end else begin
      result_num <= d_side.neg ? -qn32 : qn32;
      result_den <= qd_ext[30:0];
    end
    div_zero    <= d_side.dz;
    cmp_equal   <= d_side.eq;
    cmp_less    <= d_side.lt;
    cmp_greater <= d_side.gt;
  end

  // Exactly one comparison outcome per beat
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot({cmp_equal, cmp_less, cmp_greater}))
    else $error("comparison flags not one-hot");

  // Division by zero yields a zeroed fraction
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && div_zero) |-> (result_num == '0 && result_den == '0))
    else $error("div_zero result not zeroed");

  // Every result traces back to a start beat a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, LAT))
    else $error("result without matching start");

  // Gcd never exceeds denominator magnitude on a live beat
  a_gcd_bound: assert property (@(posedge clk) disable iff (rst)
    (g_v && !g_side.dz) |-> (g_val != '0 && g_val <= g_ud))
    else $error("gcd out of range");

endmodule

`default_nettype wire

// ===== bench/tb_rational_arithmetic_unit.sv =====
`default_nettype none

module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 16;
  localparam int LATENCY = 3 * (2 * W - 1) + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 500;

  typedef struct packed {
    logic [1:0]   cmd;
    logic [W-1:0] an;
    logic [W-2:0] ad;
    logic [W-1:0] bn;
    logic [W-2:0] bd;
    logic         drain;
  } frac_op_t;

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        dz;
    logic        eq;
    logic        lt;
    logic        gt;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command = CMD_ADD;
  logic [W-1:0] a_num = '0;
  logic [W-2:0] a_den = (W-1)'(1);
  logic [W-1:0] b_num = '0;
  logic [W-2:0] b_den = (W-1)'(1);
  logic result_valid;
  logic [31:0] result_num;
  logic [30:0] result_den;
  logic div_zero, cmp_equal, cmp_less, cmp_greater;

  frac_op_t  pending_ops[$];
  frac_res_t expected_fracs[$];
  int errors = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int cycles = 0;
  int idle_left = 0;
  bit all_queued = 1'b0;
  bit quiet_tail = 1'b0;

  rational_arithmetic_unit #(.OPERAND_WIDTH(W)) DUT (
    .clk, .rst, .start, .busy, .command, .a_num, .a_den, .b_num, .b_den,
    .result_valid, .result_num, .result_den, .div_zero,
    .cmp_equal, .cmp_less, .cmp_greater
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
    longint unsigned t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Compute the reduced fraction and the comparison flags
  function automatic frac_res_t reduce_fraction(frac_op_t op);
    frac_res_t r;
    longint an, ad, bn, bd, lhs, rhs, num, den;
    longint unsigned un, ud, g;
    an = longint'($signed(op.an));
    bn = longint'($signed(op.bn));
    ad = longint'({1'b0, op.ad});
    bd = longint'({1'b0, op.bd});
    lhs = an * bd;
    rhs = bn * ad;
    case (op.cmd)
      CMD_ADD: begin num = lhs + rhs; den = ad * bd; end
      CMD_SUB: begin num = lhs - rhs; den = ad * bd; end
      CMD_MUL: begin num = an * bn;   den = ad * bd; end
      default: begin num = lhs;       den = ad * bn; end
    endcase
    r = '0;
    if (den == 0) begin
      r.dz = 1'b1;
    end else begin
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      g = gcd_of(un, ud);
      un = un / g;
      ud = ud / g;
      r.num = ((num < 0) != (den < 0)) ? 32'(-un) : 32'(un);
      r.den = 31'(ud);
    end
    r.eq = (lhs == rhs);
    r.lt = (lhs < rhs);
    r.gt = (lhs > rhs);
    return r;
  endfunction

  function automatic logic [W-1:0] pick_num();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return '0;
      3: return W'($urandom_range(0, 20)) - W'(10);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic logic [W-2:0] pick_den();
    case ($urandom_range(0, 4))
      0: return 15'h7fff;
      1: return 15'd1;
      2: return 15'($urandom_range(1, 30));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic queue_op(logic [1:0] c, logic [W-1:0] an, logic [W-2:0] ad,
                          logic [W-1:0] bn, logic [W-2:0] bd, bit drain);
    pending_ops.push_back('{cmd: c, an: an, ad: ad, bn: bn, bd: bd, drain: drain});
  endtask

  // Fill the work list: corner fractions first, then random beats
  initial begin
    logic [1:0] c;
    for (int k = 0; k < 4; k++) begin
      c = 2'(k);
      queue_op(c, 16'h8000, 15'h7fff, 16'h7fff, 15'h0001, 1'b0);
      queue_op(c, 16'h7fff, 15'h0001, 16'h8000, 15'h7fff, 1'b0);
      queue_op(c, 16'h0000, 15'h0003, 16'h0000, 15'h0005, 1'b0);
      queue_op(c, 16'hfffe, 15'h0004, 16'h0003, 15'h0006, 1'b0);
      queue_op(c, 16'h0006, 15'h0004, 16'hfff7, 15'h0006, 1'b0);
    end
    queue_op(CMD_DIV, 16'h0007, 15'h0002, 16'h0000, 15'h0009, 1'b0);
    queue_op(CMD_DIV, 16'h8000, 15'h0001, 16'h8000, 15'h0001, 1'b0);
    queue_op(CMD_MUL, 16'h8000, 15'h0001, 16'h8000, 15'h0001, 1'b1);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_op(2'($urandom_range(0, 3)), pick_num(), pick_den(), pick_num(), pick_den(),
               i == RANDOM_ITEMS / 2);
    all_queued = 1'b1;
  end

  // Drive beats from the work list with random idle bursts
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 7) rst <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        beats_sent <= beats_sent + 1;
        if (beats_sent >= RANDOM_ITEMS - 60) quiet_tail <= 1'b1;
      end
      if (start && busy) begin
        // hold the beat
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].drain && expected_fracs.size() != 0)) begin
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
          idle_left <= $urandom_range(0, 3);
          start <= 1'b0;
        end else begin
          frac_op_t op;
          op = pending_ops.pop_front();
          command <= op.cmd;
          a_num <= op.an;
          a_den <= op.ad;
          b_num <= op.bn;
          b_den <= op.bd;
          start <= 1'b1;
          expected_fracs.push_back(reduce_fraction(op));
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result beat against the oldest prediction
  always @(posedge clk) begin
    frac_res_t exp_r;
    if (!rst && result_valid) begin
      results_seen <= results_seen + 1;
      if (expected_fracs.size() == 0) begin
        $display("%0t: unexpected result %0d/%0d", $time, $signed(result_num), result_den);
        errors <= errors + 1;
      end else begin
        exp_r = expected_fracs.pop_front();
        if (exp_r.num !== result_num || exp_r.den !== result_den || exp_r.dz !== div_zero ||
            exp_r.eq !== cmp_equal || exp_r.lt !== cmp_less || exp_r.gt !== cmp_greater) begin
          $display("%0t: mismatch expected %0d/%0d dz%b eq%b lt%b gt%b", $time,
                   $signed(exp_r.num), exp_r.den, exp_r.dz, exp_r.eq, exp_r.lt, exp_r.gt);
          $display("%0t:          actual   %0d/%0d dz%b eq%b lt%b gt%b", $time,
                   $signed(result_num), result_den, div_zero, cmp_equal, cmp_less,
                   cmp_greater);
          errors <= errors + 1;
        end
      end
    end
  end

  // Wait for the drain, then report
  initial begin
    wait (all_queued);
    while (cycles < CYCLE_LIMIT &&
           (pending_ops.size() != 0 || start || expected_fracs.size() != 0))
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
    end else begin
      $display("covered %0d fraction beats over add, sub, mul, div, %0d results checked",
               beats_sent, results_seen);
      if (errors == 0 && expected_fracs.size() == 0)
        $display("TB_OK");
      else
        $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
